>>> sv/pcb_pkg.sv
// Shared types and constants for the point convex box plane collider.
package pcb_pkg;

	localparam int MaxPlanesDef = 8;
	localparam int QDepth = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register index is paddr[2]
	localparam logic REG_PLANE_COUNT = 1'b0;
	localparam logic [3:0] PlaneCountRst = 4'd6;

	// one decoded word, edge vectors already formed
	typedef struct packed {
		logic                op;
		logic [2:0]          slot;
		logic                inv;
		logic signed [31:0]  p1x;
		logic signed [31:0]  p1y;
		logic signed [31:0]  p1z;
		logic signed [32:0]  ux;
		logic signed [32:0]  uy;
		logic signed [32:0]  uz;
		logic signed [32:0]  vx;
		logic signed [32:0]  vy;
		logic signed [32:0]  vz;
	} pcb_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pcb_qstat_t;

endpackage

>>> sv/pcb_front.sv
// Front end: accepts input words, forms edge vectors, pushes into the queue.
module pcb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [2:0]           plane_index,
	input  logic signed [31:0]   p1_x,
	input  logic signed [31:0]   p1_y,
	input  logic signed [31:0]   p1_z,
	input  logic signed [31:0]   p2_x,
	input  logic signed [31:0]   p2_y,
	input  logic signed [31:0]   p2_z,
	input  logic signed [31:0]   p3_x,
	input  logic signed [31:0]   p3_y,
	input  logic signed [31:0]   p3_z,
	input  logic                 inverted_box,
	output logic                 q_push,
	output pcb_pkg::pcb_item_t   q_item,
	input  pcb_pkg::pcb_qstat_t  q_stat
);
	import pcb_pkg::*;

	logic      valid_s1;
	pcb_item_t item_s1;

	assign in_stall = valid_s1 & q_stat.full;
	assign q_push   = valid_s1 & ~q_stat.full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.op   <= op;
			item_s1.slot <= plane_index;
			item_s1.inv  <= inverted_box;
			item_s1.p1x  <= p1_x;
			item_s1.p1y  <= p1_y;
			item_s1.p1z  <= p1_z;
			item_s1.ux   <= {p2_x[31], p2_x} - {p1_x[31], p1_x};
			item_s1.uy   <= {p2_y[31], p2_y} - {p1_y[31], p1_y};
			item_s1.uz   <= {p2_z[31], p2_z} - {p1_z[31], p1_z};
			item_s1.vx   <= {p3_x[31], p3_x} - {p1_x[31], p1_x};
			item_s1.vy   <= {p3_y[31], p3_y} - {p1_y[31], p1_y};
			item_s1.vz   <= {p3_z[31], p3_z} - {p1_z[31], p1_z};
		end
	end

endmodule

>>> sv/pcb_fifo.sv
// Short queue between the front end and the execution engine.
module pcb_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pcb_pkg::pcb_item_t   push_item,
	input  logic                 pop,
	output pcb_pkg::pcb_item_t   pop_item,
	output pcb_pkg::pcb_qstat_t  stat
);
	import pcb_pkg::*;

	localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW = $clog2(QDepth + 1);

	pcb_item_t       mem_q [QDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CntW'(QDepth));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

>>> sv/pcb_back.sv
// Execution engine: plane normalization on loads, plane walk on queries.
module pcb_back #(
	parameter int MAX_PLANES = pcb_pkg::MaxPlanesDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcb_pkg::pcb_qstat_t  q_stat,
	output logic                 q_pop,
	input  pcb_pkg::pcb_item_t   q_item,
	input  logic [3:0]           plane_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic signed [31:0]   normal_x,
	output logic signed [31:0]   normal_y,
	output logic signed [31:0]   normal_z
);
	import pcb_pkg::*;

	localparam int IdxW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int CntW = $clog2(MAX_PLANES + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SHR   = 4'd1;
	localparam logic [3:0] S_CRS   = 4'd2;
	localparam logic [3:0] S_CMAG  = 4'd3;
	localparam logic [3:0] S_NRM   = 4'd4;
	localparam logic [3:0] S_SQS   = 4'd5;
	localparam logic [3:0] S_SQRT  = 4'd6;
	localparam logic [3:0] S_DINIT = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_OFS   = 4'd9;
	localparam logic [3:0] S_QRY   = 4'd10;
	localparam logic [3:0] S_QEV   = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0]          state_q;
	logic                inv_q;
	logic                slot_ok_q;
	logic [IdxW-1:0]     slot_q;
	logic signed [31:0]  p1_q [3];
	logic [32:0]         um_q [3];
	logic [32:0]         vm_q [3];
	logic                us_q [3];
	logic                vs_q [3];
	logic signed [61:0]  c_q [3];
	logic [61:0]         m_q [3];
	logic                cneg_q [3];
	logic [2:0]          step_q;
	logic signed [63:0]  prod_q;
	logic [63:0]         acc_q;
	logic [63:0]         x_q;
	logic [63:0]         r_q;
	logic [63:0]         bit_q;
	logic [31:0]         len_q;
	logic [31:0]         rem_q;
	logic [30:0]         num_q;
	logic [29:0]         quo_q;
	logic [4:0]          dcnt_q;
	logic [1:0]          ci_q;
	logic signed [31:0]  nrm_q [3];
	logic signed [31:0]  pn_q [MAX_PLANES][3];
	logic signed [47:0]  po_q [MAX_PLANES];
	logic [CntW-1:0]     cnt_q;
	logic [CntW-1:0]     k_q;
	logic [IdxW-1:0]     best_q;
	logic                best_v_q;
	logic signed [48:0]  best_d_q;
	logic                res_hit_q;
	logic signed [31:0]  res_n_q [3];
	logic                out_valid_q;
	logic                hit_q;
	logic signed [31:0]  nx_q;
	logic signed [31:0]  ny_q;
	logic signed [31:0]  nz_q;

	logic signed [31:0]  uval [3];
	logic signed [31:0]  vval [3];
	logic [1:0]          sidx;
	logic [IdxW-1:0]     kidx;
	logic signed [31:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [63:0]  mul_p;
	logic                u_big;
	logic                v_big;
	logic                n_small;
	logic                n_big;
	logic                c_zero;
	logic [63:0]         rb;
	logic                sq_ge;
	logic [63:0]         rn;
	logic [63:0]         xn;
	logic [32:0]         rem2;
	logic                dge;
	logic [31:0]         remn;
	logic [61:0]         numfull;
	logic [30:0]         quo_fin;
	logic signed [63:0]  tot;
	logic signed [63:0]  tot_sh;
	logic signed [63:0]  acc_sh;
	logic signed [48:0]  pdist;
	logic                take;
	logic [IdxW-1:0]     fbest;
	logic [5:0]          pc_ext;
	logic [5:0]          pc_eff;
	logic [5:0]          slot_ext;
	logic                out_free;

	assign q_pop    = (state_q == S_IDLE) & ~q_stat.empty;
	assign out_free = ~out_valid_q | ~out_stall;
	assign kidx     = k_q[IdxW-1:0];
	assign sidx     = (step_q[1:0] == 2'd3) ? 2'd0 : step_q[1:0];

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign normal_z  = nz_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uval[i] = us_q[i] ? -$signed({1'b0, um_q[i][30:0]}) : $signed({1'b0, um_q[i][30:0]});
			vval[i] = vs_q[i] ? -$signed({1'b0, vm_q[i][30:0]}) : $signed({1'b0, vm_q[i][30:0]});
		end
	end

	// single shared multiplier, operands picked per state and step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CRS: begin
				case (step_q)
					3'd0: begin mul_a = uval[1]; mul_b = vval[2]; end
					3'd1: begin mul_a = uval[2]; mul_b = vval[1]; end
					3'd2: begin mul_a = uval[2]; mul_b = vval[0]; end
					3'd3: begin mul_a = uval[0]; mul_b = vval[2]; end
					3'd4: begin mul_a = uval[0]; mul_b = vval[1]; end
					3'd5: begin mul_a = uval[1]; mul_b = vval[0]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_SQS: begin
				mul_a = $signed({1'b0, m_q[sidx][30:0]});
				mul_b = $signed({1'b0, m_q[sidx][30:0]});
			end
			S_OFS: begin
				mul_a = nrm_q[sidx];
				mul_b = p1_q[sidx];
			end
			S_QRY: begin
				mul_a = pn_q[kidx][sidx];
				mul_b = p1_q[sidx];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		u_big   = 1'b0;
		v_big   = 1'b0;
		n_small = 1'b1;
		n_big   = 1'b0;
		c_zero  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			u_big   = u_big | (um_q[i][32:30] != '0);
			v_big   = v_big | (vm_q[i][32:30] != '0);
			n_small = n_small & (m_q[i][61:30] == '0);
			n_big   = n_big | (m_q[i][61:31] != '0);
			c_zero  = c_zero & (c_q[i] == '0);
		end
	end

	// integer square root, one result bit per cycle
	assign rb    = r_q + bit_q;
	assign sq_ge = (x_q >= rb);
	assign rn    = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
	assign xn    = sq_ge ? (x_q - rb) : x_q;

	// restoring divide, one quotient bit per cycle
	assign rem2    = {rem_q, num_q[30]};
	assign dge     = (rem2 >= {1'b0, len_q});
	assign remn    = dge ? 32'(rem2 - {1'b0, len_q}) : rem2[31:0];
	assign numfull = {1'b0, m_q[ci_q][30:0], 30'b0} + {31'b0, len_q[31:1]};
	assign quo_fin = {quo_q, dge};

	assign tot    = $signed(acc_q) + prod_q;
	assign tot_sh = tot >>> 16;
	// in S_QEV acc_q already holds the full dot product
	assign acc_sh = $signed(acc_q) >>> 16;
	assign pdist  = $signed({acc_sh[47], acc_sh[47:0]}) - $signed({po_q[kidx][47], po_q[kidx]});
	assign take   = ~best_v_q | (pdist > best_d_q);
	assign fbest  = take ? kidx : best_q;

	assign pc_ext   = {2'b0, plane_count};
	assign pc_eff   = (pc_ext > 6'(MAX_PLANES)) ? 6'(MAX_PLANES) : pc_ext;
	assign slot_ext = {3'b0, q_item.slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_p;
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						inv_q     <= q_item.inv;
						slot_ok_q <= (slot_ext < 6'(MAX_PLANES));
						slot_q    <= slot_ext[IdxW-1:0];
						p1_q[0]   <= q_item.p1x;
						p1_q[1]   <= q_item.p1y;
						p1_q[2]   <= q_item.p1z;
						um_q[0]   <= q_item.ux[32] ? 33'(-q_item.ux) : q_item.ux;
						um_q[1]   <= q_item.uy[32] ? 33'(-q_item.uy) : q_item.uy;
						um_q[2]   <= q_item.uz[32] ? 33'(-q_item.uz) : q_item.uz;
						vm_q[0]   <= q_item.vx[32] ? 33'(-q_item.vx) : q_item.vx;
						vm_q[1]   <= q_item.vy[32] ? 33'(-q_item.vy) : q_item.vy;
						vm_q[2]   <= q_item.vz[32] ? 33'(-q_item.vz) : q_item.vz;
						us_q[0]   <= q_item.ux[32];
						us_q[1]   <= q_item.uy[32];
						us_q[2]   <= q_item.uz[32];
						vs_q[0]   <= q_item.vx[32];
						vs_q[1]   <= q_item.vy[32];
						vs_q[2]   <= q_item.vz[32];
						cnt_q     <= pc_eff[CntW-1:0];
						k_q       <= '0;
						best_v_q  <= 1'b0;
						step_q    <= '0;
						res_hit_q <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							res_n_q[i] <= '0;
						end
						if (q_item.op == OP_LOAD) begin
							state_q <= S_SHR;
						end else if (pc_eff == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_QRY;
						end
					end
				end
				S_SHR: begin
					// each edge vector halves on its own until it fits 30 bits
					for (int i = 0; i < 3; i++) begin
						if (u_big) um_q[i] <= um_q[i] >> 1;
						if (v_big) vm_q[i] <= vm_q[i] >> 1;
					end
					if (!u_big && !v_big) begin
						step_q  <= '0;
						state_q <= S_CRS;
					end
				end
				S_CRS: begin
					case (step_q)
						3'd1: c_q[0] <= prod_q[61:0];
						3'd2: c_q[0] <= c_q[0] - prod_q[61:0];
						3'd3: c_q[1] <= prod_q[61:0];
						3'd4: c_q[1] <= c_q[1] - prod_q[61:0];
						3'd5: c_q[2] <= prod_q[61:0];
						3'd6: c_q[2] <= c_q[2] - prod_q[61:0];
						default: ;
					endcase
					step_q <= step_q + 1'b1;
					if (step_q == 3'd6) begin
						state_q <= S_CMAG;
					end
				end
				S_CMAG: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]    <= c_q[i][61] ? 62'(-c_q[i]) : c_q[i];
						cneg_q[i] <= c_q[i][61];
						nrm_q[i]  <= '0;
					end
					step_q <= '0;
					// degenerate plane: zero normal gives zero offset too
					state_q <= c_zero ? S_OFS : S_NRM;
				end
				S_NRM: begin
					for (int i = 0; i < 3; i++) begin
						if (n_small) m_q[i] <= m_q[i] << 1;
						else if (n_big) m_q[i] <= m_q[i] >> 1;
					end
					if (!n_small && !n_big) begin
						step_q  <= '0;
						state_q <= S_SQS;
					end
				end
				S_SQS: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1) begin
						acc_q <= prod_q;
					end else if (step_q == 3'd2) begin
						acc_q <= tot;
					end else if (step_q == 3'd3) begin
						x_q     <= tot;
						r_q     <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					x_q   <= xn;
					r_q   <= rn;
					bit_q <= bit_q >> 2;
					if (bit_q == 64'd1) begin
						len_q   <= rn[31:0];
						ci_q    <= '0;
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					rem_q   <= {1'b0, numfull[61:31]};
					num_q   <= numfull[30:0];
					quo_q   <= '0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= remn;
					num_q  <= num_q << 1;
					quo_q  <= quo_fin[29:0];
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'd30) begin
						nrm_q[ci_q] <= cneg_q[ci_q] ? -$signed({1'b0, quo_fin})
						                             : $signed({1'b0, quo_fin});
						if (ci_q == 2'd2) begin
							step_q  <= '0;
							state_q <= S_OFS;
						end else begin
							ci_q    <= ci_q + 1'b1;
							state_q <= S_DINIT;
						end
					end
				end
				S_OFS: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1) begin
						acc_q <= prod_q;
					end else if (step_q == 3'd2) begin
						acc_q <= tot;
					end else if (step_q == 3'd3) begin
						if (slot_ok_q) begin
							for (int i = 0; i < 3; i++) begin
								pn_q[slot_q][i] <= nrm_q[i];
							end
							po_q[slot_q] <= tot_sh[47:0];
						end
						state_q <= S_DONE;
					end
				end
				S_QRY: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1) begin
						acc_q <= prod_q;
					end else if (step_q == 3'd2 || step_q == 3'd3) begin
						acc_q <= tot;
						if (step_q == 3'd3) begin
							state_q <= S_QEV;
						end
					end
				end
				S_QEV: begin
					// acc_q holds the full dot product here; prod_q is not added
					if (inv_q) begin
						if (!pdist[48]) begin
							res_hit_q <= 1'b1;
							for (int i = 0; i < 3; i++) begin
								res_n_q[i] <= -pn_q[kidx][i];
							end
							state_q <= S_DONE;
						end else if (k_q + 1'b1 == cnt_q) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							step_q  <= '0;
							state_q <= S_QRY;
						end
					end else begin
						if (!pdist[48] && pdist != '0) begin
							state_q <= S_DONE;
						end else begin
							best_v_q <= 1'b1;
							best_q   <= fbest;
							if (take) best_d_q <= pdist;
							if (k_q + 1'b1 == cnt_q) begin
								res_hit_q <= 1'b1;
								for (int i = 0; i < 3; i++) begin
									res_n_q[i] <= pn_q[fbest][i];
								end
								state_q <= S_DONE;
							end else begin
								k_q     <= k_q + 1'b1;
								step_q  <= '0;
								state_q <= S_QRY;
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= res_hit_q;
						nx_q        <= res_n_q[0];
						ny_q        <= res_n_q[1];
						nz_q        <= res_n_q[2];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// in S_QEV the distance comes from acc_q alone; tot would add a stale prod_q
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (nx_q == '0 && ny_q == '0 && nz_q == '0))
		else $error("miss word carries a nonzero normal");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE && !out_valid_q) || (state_q == S_IDLE))
		else $error("queue popped while engine busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQS && step_q == 3'd0) |->
		(m_q[0][61:31] == '0 && m_q[1][61:31] == '0 && m_q[2][61:31] == '0))
		else $error("cross product not normalized below 2^31");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < len_q && len_q[31:30] != 2'b00))
		else $error("divider remainder out of range");

endmodule

>>> sv/point_convex_box_plane_collider_top.sv
// Top level of the point convex box plane collider: APB register and block wiring.
// Every input word yields one output word. A load (op 0) turns three corner points
// into a unit plane normal (Q2.30) and offset and stores them in slot plane_index;
// its word is a plain acknowledgement with hit 0. A query (op 1) tests a point
// against planes 0..plane_count-1 (capped at MAX_PLANES) and returns hit plus the
// contact normal. Words are executed one at a time by a single engine with one
// shared 32x32 multiplier, a bit-serial square root and a bit-serial divider: a
// load runs the normalizing shift, the root and the three divides (all skipped for
// a degenerate plane), and a query runs three multiplies, the sum and one compare
// per plane examined, stopping early at the deciding plane. A two-word queue lets
// the input side keep taking words while the engine works, and the output register
// frees the engine while a result waits.
module point_convex_box_plane_collider_top #(
	parameter int MAX_PLANES = pcb_pkg::MaxPlanesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [2:0]          plane_index,
	input  logic signed [31:0]  p1_x,
	input  logic signed [31:0]  p1_y,
	input  logic signed [31:0]  p1_z,
	input  logic signed [31:0]  p2_x,
	input  logic signed [31:0]  p2_y,
	input  logic signed [31:0]  p2_z,
	input  logic signed [31:0]  p3_x,
	input  logic signed [31:0]  p3_y,
	input  logic signed [31:0]  p3_z,
	input  logic                inverted_box,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic signed [31:0]  normal_x,
	output logic signed [31:0]  normal_y,
	output logic signed [31:0]  normal_z,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import pcb_pkg::*;

	logic        plane_count_q;
	logic [3:0]  pcount_q;
	logic        q_push;
	logic        q_pop;
	pcb_item_t   push_item;
	pcb_item_t   pop_item;
	pcb_qstat_t  q_stat;

	assign pready = 1'b1;
	assign plane_count_q = (paddr[2] == REG_PLANE_COUNT);
	assign prdata = plane_count_q ? {28'b0, pcount_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= PlaneCountRst;
		end else if (psel && penable && pwrite && pready && plane_count_q) begin
			pcount_q <= pwdata[3:0];
		end
	end

	pcb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.plane_index  (plane_index),
		.p1_x         (p1_x),
		.p1_y         (p1_y),
		.p1_z         (p1_z),
		.p2_x         (p2_x),
		.p2_y         (p2_y),
		.p2_z         (p2_z),
		.p3_x         (p3_x),
		.p3_y         (p3_y),
		.p3_z         (p3_z),
		.inverted_box (inverted_box),
		.q_push       (q_push),
		.q_item       (push_item),
		.q_stat       (q_stat)
	);

	pcb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	pcb_back #(
		.MAX_PLANES (MAX_PLANES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.q_item      (pop_item),
		.plane_count (pcount_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z)
	);

endmodule
